>>> src/bernoulli_mixture_loglik_unit_defines.svh
// Assertion macros shared by the checker of the Bernoulli mixture log-likelihood unit.
`ifndef BERNOULLI_MIXTURE_LOGLIK_UNIT_DEFINES_SVH
`define BERNOULLI_MIXTURE_LOGLIK_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define BMLL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define BMLL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/bmll_pkg.sv
// Types and constants of the Bernoulli mixture log-likelihood unit.
`timescale 1ns / 1ps
package bmll_pkg;
	localparam int MAX_DIMS       = 32;
	localparam int MAX_COMPONENTS = 8;

	localparam int OP_W    = 2;
	localparam int COMP_W  = 3;
	localparam int DIM_W   = 5;
	localparam int LOG_W   = 32;
	localparam int BITS_W  = 32;
	localparam int RESP_W  = 17;
	localparam int TOTAL_W = 64;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	localparam int NDIM_W     = 6;
	localparam int NCOMP_W    = 4;

	localparam int COMP_ADDR_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int GROUP       = 8;
	localparam int NGROUPS     = (MAX_DIMS + GROUP - 1) / GROUP;
	localparam int PART_W      = LOG_W + $clog2(GROUP) + 1;
	localparam int TERM_W      = LOG_W + $clog2(MAX_DIMS + 1) + 1;
	localparam int PROD_W      = TERM_W + RESP_W + 1;
	localparam int UNW_SHIFT   = 16;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_ONE    = 2'd0,
		OP_LOAD_ZERO   = 2'd1,
		OP_LOAD_WEIGHT = 2'd2,
		OP_SCORE       = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WEIGHT_MODE       = 2'd0,
		CFG_DIMS_IN_USE       = 2'd1,
		CFG_COMPONENTS_IN_USE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic              active;
		logic              last;
		logic              unweighted;
		logic [RESP_W-1:0] resp;
	} score_ctl_t;
endpackage

>>> src/bmll_if.sv
// Valid/ready channel interfaces for score and load items and for result beats.
`timescale 1ns / 1ps
interface bmll_in_if;
	logic                                valid;
	logic                                ready;
	logic [bmll_pkg::OP_W-1:0]           operation;
	logic [bmll_pkg::COMP_W-1:0]         component;
	logic [bmll_pkg::DIM_W-1:0]          dimension;
	logic signed [bmll_pkg::LOG_W-1:0]   log_value;
	logic [bmll_pkg::BITS_W-1:0]         sample_bits;
	logic [bmll_pkg::RESP_W-1:0]         responsibility;
	logic                                last_term;

	modport source (output valid, operation, component, dimension, log_value, sample_bits,
		responsibility, last_term, input ready);
	modport sink (input valid, operation, component, dimension, log_value, sample_bits,
		responsibility, last_term, output ready);
endinterface

interface bmll_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [bmll_pkg::TOTAL_W-1:0] log_likelihood;
	logic                                saturated;

	modport source (output valid, log_likelihood, saturated, input ready);
	modport sink (input valid, log_likelihood, saturated, output ready);
endinterface

>>> src/bernoulli_mixture_loglik_unit.sv
// Top level of the Bernoulli mixture log-likelihood unit.
// Throughput: one item per cycle unless stalled; all dimension tables are read in parallel.
// The last score item passes stages s1 to s4 before the result register takes its total.
// The input stalls only while a last item waits for a result register that is still full.
// Reset clears the configuration to its defaults, the accumulator, the overflow flag and
// all stage valid bits; the log tables keep their contents and are defined once loaded.
`timescale 1ns / 1ps
module bernoulli_mixture_loglik_unit (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [bmll_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bmll_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	bmll_in_if.sink                                item,
	bmll_out_if.source                             result
);
	import bmll_pkg::*;

	logic                      weight_mode_q;
	logic [NDIM_W-1:0]         dims_q;
	logic [NCOMP_W-1:0]        comps_q;

	logic                      en;
	logic                      accept;
	logic                      is_score;
	logic                      comp_ok;
	logic [NDIM_W-1:0]         nd;
	logic [MAX_DIMS+BITS_W-1:0] bits_ext;
	logic [MAX_DIMS-1:0]       one_mask;
	logic [MAX_DIMS-1:0]       zero_mask;
	logic [COMP_ADDR_W-1:0]    addr;

	logic                      valid_s1;
	score_ctl_t                ctl_s1;
	logic [MAX_DIMS-1:0]       one_mask_s1;
	logic [MAX_DIMS-1:0]       zero_mask_s1;

	logic [LOG_W-1:0]          one_rd  [MAX_DIMS];
	logic [LOG_W-1:0]          zero_rd [MAX_DIMS];
	logic [LOG_W-1:0]          weight_rd;

	logic                      valid_s3;
	score_ctl_t                ctl_s3;
	logic signed [TERM_W-1:0]  term_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_mode_q <= 1'b0;
			dims_q        <= NDIM_W'(MAX_DIMS);
			comps_q       <= NCOMP_W'(MAX_COMPONENTS);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WEIGHT_MODE:       weight_mode_q <= cfg_wdata[0];
				CFG_DIMS_IN_USE:       dims_q        <= cfg_wdata[NDIM_W-1:0];
				CFG_COMPONENTS_IN_USE: comps_q       <= cfg_wdata[NCOMP_W-1:0];
				default: ;
			endcase
		end
	end

	assign item.ready = en;
	assign accept     = item.valid && en;
	assign is_score   = item.operation == OP_SCORE;
	assign comp_ok    = (COMP_W+1)'(item.component) < (COMP_W+1)'(MAX_COMPONENTS);
	assign addr       = COMP_ADDR_W'(item.component);
	assign nd         = (dims_q > NDIM_W'(MAX_DIMS)) ? NDIM_W'(MAX_DIMS) : dims_q;
	assign bits_ext   = {{MAX_DIMS{1'b0}}, item.sample_bits};

	always_comb begin
		for (int k = 0; k < MAX_DIMS; k++) begin
			one_mask[k]  = (NDIM_W'(k) < nd) && bits_ext[k];
			zero_mask[k] = (NDIM_W'(k) < nd) && !bits_ext[k];
		end
	end

	for (genvar k = 0; k < MAX_DIMS; k++) begin : g_dim
		bmll_ram #(.WIDTH(LOG_W), .DEPTH(MAX_COMPONENTS)) u_one_ram (
			.clk   (clk),
			.we    (accept && comp_ok && item.operation == OP_LOAD_ONE &&
				item.dimension == DIM_W'(k)),
			.waddr (addr),
			.wdata (item.log_value),
			.re    (accept && is_score),
			.raddr (addr),
			.rdata (one_rd[k])
		);
		bmll_ram #(.WIDTH(LOG_W), .DEPTH(MAX_COMPONENTS)) u_zero_ram (
			.clk   (clk),
			.we    (accept && comp_ok && item.operation == OP_LOAD_ZERO &&
				item.dimension == DIM_W'(k)),
			.waddr (addr),
			.wdata (item.log_value),
			.re    (accept && is_score),
			.raddr (addr),
			.rdata (zero_rd[k])
		);
	end

	bmll_ram #(.WIDTH(LOG_W), .DEPTH(MAX_COMPONENTS)) u_weight_ram (
		.clk   (clk),
		.we    (accept && comp_ok && item.operation == OP_LOAD_WEIGHT),
		.waddr (addr),
		.wdata (item.log_value),
		.re    (accept && is_score),
		.raddr (addr),
		.rdata (weight_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= accept && is_score;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.active     <= comp_ok && ((NCOMP_W+1)'(item.component) <
				(NCOMP_W+1)'(comps_q));
			ctl_s1.last       <= item.last_term;
			ctl_s1.unweighted <= weight_mode_q;
			ctl_s1.resp       <= item.responsibility;
			one_mask_s1       <= one_mask;
			zero_mask_s1      <= zero_mask;
		end
	end

	bmll_sum u_sum (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.valid_s1     (valid_s1),
		.ctl_s1       (ctl_s1),
		.one_mask_s1  (one_mask_s1),
		.zero_mask_s1 (zero_mask_s1),
		.one_rd       (one_rd),
		.zero_rd      (zero_rd),
		.weight_rd    (weight_rd),
		.valid_s3     (valid_s3),
		.ctl_s3       (ctl_s3),
		.term_s3      (term_s3)
	);

	bmll_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s3  (valid_s3),
		.ctl_s3    (ctl_s3),
		.term_s3   (term_s3),
		.en        (en),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_total (result.log_likelihood),
		.out_sat   (result.saturated)
	);
endmodule

>>> src/bmll_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module bmll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> src/bmll_sum.sv
// Two-stage adder tree that forms the component term from the table read data.
`timescale 1ns / 1ps
module bmll_sum (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  valid_s1,
	input  bmll_pkg::score_ctl_t                  ctl_s1,
	input  logic [bmll_pkg::MAX_DIMS-1:0]         one_mask_s1,
	input  logic [bmll_pkg::MAX_DIMS-1:0]         zero_mask_s1,
	input  logic [bmll_pkg::LOG_W-1:0]            one_rd [bmll_pkg::MAX_DIMS],
	input  logic [bmll_pkg::LOG_W-1:0]            zero_rd [bmll_pkg::MAX_DIMS],
	input  logic [bmll_pkg::LOG_W-1:0]            weight_rd,
	output logic                                  valid_s3,
	output bmll_pkg::score_ctl_t                  ctl_s3,
	output logic signed [bmll_pkg::TERM_W-1:0]    term_s3
);
	import bmll_pkg::*;

	logic signed [PART_W-1:0] part      [NGROUPS];
	logic signed [PART_W-1:0] part_s2   [NGROUPS];
	logic signed [LOG_W-1:0]  weight_s2;
	logic                     valid_s2;
	score_ctl_t               ctl_s2;
	logic signed [TERM_W-1:0] term;

	always_comb begin
		int idx;
		logic signed [PART_W-1:0] acc;
		for (int g = 0; g < NGROUPS; g++) begin
			acc = '0;
			for (int j = 0; j < GROUP; j++) begin
				idx = g * GROUP + j;
				if (idx < MAX_DIMS) begin
					if (one_mask_s1[idx]) begin
						acc = acc + PART_W'(signed'(one_rd[idx]));
					end else if (zero_mask_s1[idx]) begin
						acc = acc + PART_W'(signed'(zero_rd[idx]));
					end
				end
			end
			part[g] = acc;
		end
	end

	always_comb begin
		term = TERM_W'(weight_s2);
		for (int g = 0; g < NGROUPS; g++) begin
			term = term + TERM_W'(part_s2[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			part_s2   <= part;
			weight_s2 <= signed'(weight_rd);
			ctl_s2    <= ctl_s1;
			term_s3   <= term;
			ctl_s3    <= ctl_s2;
		end
	end
endmodule

>>> src/bmll_acc.sv
// Responsibility multiply (a left shift in unweighted mode), saturating accumulator and result register.
`timescale 1ns / 1ps
module bmll_acc (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_s3,
	input  bmll_pkg::score_ctl_t                ctl_s3,
	input  logic signed [bmll_pkg::TERM_W-1:0]  term_s3,
	output logic                                en,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [bmll_pkg::TOTAL_W-1:0] out_total,
	output logic                                out_sat
);
	import bmll_pkg::*;

	localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
	localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

	logic                      valid_s4;
	score_ctl_t                ctl_s4;
	logic signed [PROD_W-1:0]  prod;
	logic signed [PROD_W-1:0]  prod_s4;
	logic signed [TOTAL_W:0]   sum;
	logic                      ovf;
	logic signed [TOTAL_W-1:0] next_total;
	logic signed [TOTAL_W-1:0] total_q;
	logic                      ovf_seen_q;
	logic                      take;

	assign en   = !(valid_s4 && ctl_s4.last && out_valid && !out_ready);
	assign take = valid_s4 && en;

	always_comb begin
		if (!ctl_s3.active) begin
			prod = '0;
		end else if (ctl_s3.unweighted) begin
			prod = PROD_W'(signed'({term_s3, {UNW_SHIFT{1'b0}}}));
		end else begin
			prod = PROD_W'(term_s3 * signed'({1'b0, ctl_s3.resp}));
		end
	end

	always_comb begin
		sum = {total_q[TOTAL_W-1], total_q} + (TOTAL_W+1)'(prod_s4);
		ovf = sum[TOTAL_W] ^ sum[TOTAL_W-1];
		if (ovf) begin
			next_total = sum[TOTAL_W] ? TOTAL_MIN : TOTAL_MAX;
		end else begin
			next_total = sum[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4   <= 1'b0;
			total_q    <= '0;
			ovf_seen_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (en) begin
				valid_s4 <= valid_s3;
			end
			if (take) begin
				if (ctl_s4.last) begin
					total_q    <= '0;
					ovf_seen_q <= 1'b0;
				end else begin
					total_q    <= next_total;
					ovf_seen_q <= ovf_seen_q | ovf;
				end
			end
			if (take && ctl_s4.last) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s4  <= ctl_s3;
			prod_s4 <= prod;
		end
		if (take && ctl_s4.last) begin
			out_total <= next_total;
			out_sat   <= ovf_seen_q | ovf;
		end
	end
endmodule

>>> src/bmll_checker.sv
// Port-level checker for the Bernoulli mixture log-likelihood unit, with its bind.
`timescale 1ns / 1ps
`include "bernoulli_mixture_loglik_unit_defines.svh"
module bmll_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [bmll_pkg::OP_W-1:0]           in_operation,
	input logic                                in_last,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [bmll_pkg::TOTAL_W-1:0]        out_total,
	input logic                                out_sat
);
	import bmll_pkg::*;

	logic last_score_beat;

	assign last_score_beat = in_valid && in_ready && in_operation == OP_SCORE && in_last;

	`BMLL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
	`BMLL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_total) && $stable(out_sat), "stalled result beat changed")
	`BMLL_ASSERT_NOW(a_ready_free, !in_ready, out_valid && !out_ready, "input stalled with a free result register")
	`BMLL_ASSERT_NEXT(a_latency, $past(last_score_beat, 4) && $past(out_ready, 3) && $past(out_ready, 2) && $past(out_ready, 1) && out_ready, out_valid, "last score item gave no result beat in time")
endmodule

bind bernoulli_mixture_loglik_unit bmll_checker u_bmll_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (item.valid),
	.in_ready     (item.ready),
	.in_operation (item.operation),
	.in_last      (item.last_term),
	.out_valid    (result.valid),
	.out_ready    (result.ready),
	.out_total    (result.log_likelihood),
	.out_sat      (result.saturated)
);
